### src/cttr_pkg.sv
// Shared types and constants for the color text parser.
package cttr_pkg;

	// Path chosen by the first character of a text
	typedef enum logic [1:0] {
		PATH_WAIT = 2'd0,
		PATH_HEX  = 2'd1,
		PATH_DEC  = 2'd2,
		PATH_BAD  = 2'd3
	} path_t;

	// Hex number scanner phases
	typedef enum logic [2:0] {
		PH_WS     = 3'd0,
		PH_SIGNED = 3'd1,
		PH_ZERO   = 3'd2,
		PH_ZEROX  = 3'd3,
		PH_DIGITS = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	// Character classes produced by the front end
	typedef struct packed {
		logic       term;    // zero byte, ends the text
		logic       hash;    // '#'
		logic       dec;     // '0'..'9'
		logic       hex;     // any hex digit
		logic [3:0] digit;   // hex value of the digit (covers decimal digits)
		logic       ws;      // space, TAB, LF, VT, FF, CR
		logic       plus;    // '+'
		logic       minus;   // '-'
		logic       zero_ch; // '0'
		logic       x_ch;    // 'x' or 'X'
	} char_class_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	localparam int unsigned TDATA_OUT_W = 32;
	localparam logic [3:0]  MAX_LEN     = 4'd8;
	localparam logic [3:0]  HEX_LONG    = 4'd6;
	localparam logic [3:0]  HEX_SHORT   = 4'd3;

	// RGB565 expansion: (c * mul + add) >> 6
	localparam logic [13:0] RB_MUL = 14'd527;
	localparam logic [13:0] RB_ADD = 14'd23;
	localparam logic [13:0] G_MUL  = 14'd259;
	localparam logic [13:0] G_ADD  = 14'd33;

endpackage

### src/color_text_to_rgb_parser.sv
// Top level of the color text parser: front end, character queue, back end.
// A terminator is written into the queue first; the back end then pops it from the queue head
//   and writes its result into the output register; each back-end step updates small accumulators.
// Throughput: one character per cycle while the queue has room.
// Stalls on the result side hold only terminators; characters queued behind a held one wait.
// Reset: arst_n asynchronous, active low; clears queue, parser state and output valid.
module color_text_to_rgb_parser #(
	parameter int unsigned QUEUE_DEPTH = 4  // character queue entries
) (
	input  logic        clk,
	input  logic        arst_n,
	// input characters, one transfer per character
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	// one result transfer per terminated text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [0] ok, [8:1] red, [16:9] green, [24:17] blue, rest 0
);

	// front -> queue
	logic                  push;
	cttr_pkg::char_class_t push_data;
	logic                  queue_ready;

	// queue -> back
	logic                  head_valid;
	cttr_pkg::char_class_t head_data;
	logic                  pop;

	// Front end classifies each character in the cycle it arrives.
	cttr_front u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.push        (push),
		.push_data   (push_data),
		.queue_ready (queue_ready)
	);

	// Decouples input acceptance from result back-pressure.
	cttr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.ready      (queue_ready),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	// Back end runs the parser and owns the output register.
	cttr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (head_valid),
		.q_data   (head_data),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### src/cttr_front.sv
// Front end: accepts characters, classifies them and enqueues the class.
module cttr_front (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] ch
	output logic                  push,
	output cttr_pkg::char_class_t push_data,
	input  logic                  queue_ready
);

	function automatic cttr_pkg::char_class_t classify(input logic [7:0] c);
		cttr_pkg::char_class_t k;
		k         = '0;
		k.term    = (c == 8'h00);
		k.hash    = (c == 8'h23);
		k.ws      = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
		k.plus    = (c == 8'h2b);
		k.minus   = (c == 8'h2d);
		k.zero_ch = (c == 8'h30);
		k.x_ch    = (c == 8'h78) || (c == 8'h58);
		if (c >= 8'h30 && c <= 8'h39) begin
			k.dec   = 1'b1;
			k.hex   = 1'b1;
			k.digit = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			k.hex   = 1'b1;
			k.digit = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			k.hex   = 1'b1;
			k.digit = 4'(c - 8'h37);
		end
		return k;
	endfunction

	assign s_tready  = queue_ready;
	assign push      = s_tvalid & queue_ready;
	assign push_data = classify(s_tdata);

endmodule

### src/cttr_queue.sv
// Small FIFO of classified characters between front and back end.
module cttr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cttr_pkg::char_class_t push_data,
	output logic                  ready,
	output logic                  head_valid,
	output cttr_pkg::char_class_t head_data,
	input  logic                  pop
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cttr_pkg::char_class_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign ready      = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push & ready;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/cttr_back.sv
// Back end: text state, hex/decimal accumulation, color result register.
module cttr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  cttr_pkg::char_class_t q_data,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [cttr_pkg::TDATA_OUT_W-1:0] m_tdata
);

	cttr_pkg::path_t  path_q,  path_d;
	cttr_pkg::phase_t phase_q, phase_d;
	logic [3:0]  len_q,  len_d;
	logic        neg_q,  neg_d;
	logic [23:0] hval_q, hval_d;
	logic [3:0]  cons_q, cons_d;
	logic [15:0] dval_q, dval_d;

	logic            out_valid_q;
	cttr_pkg::color_t out_q;
	cttr_pkg::color_t res;

	logic        take;
	logic        take_digit;
	logic [23:0] hv;
	logic [13:0] r_mul, g_mul, b_mul;

	// a terminator needs the output slot; other characters never wait
	assign take  = q_valid & (~q_data.term | ~out_valid_q | m_tready);
	assign q_pop = take;

	// result from current state
	always_comb begin
		res   = '0;
		hv    = neg_q ? (24'd0 - hval_q) : hval_q;
		r_mul = 14'(dval_q[15:11]) * cttr_pkg::RB_MUL + cttr_pkg::RB_ADD;
		g_mul = 14'(dval_q[10:5]) * cttr_pkg::G_MUL + cttr_pkg::G_ADD;
		b_mul = 14'(dval_q[4:0]) * cttr_pkg::RB_MUL + cttr_pkg::RB_ADD;
		if (path_q == cttr_pkg::PATH_HEX && len_q < cttr_pkg::MAX_LEN) begin
			if (cons_q == cttr_pkg::HEX_LONG) begin
				res.ok    = 1'b1;
				res.red   = hv[23:16];
				res.green = hv[15:8];
				res.blue  = hv[7:0];
			end else if (cons_q == cttr_pkg::HEX_SHORT) begin
				res.ok    = 1'b1;
				res.red   = {hv[11:8], hv[11:8]};
				res.green = {hv[7:4], hv[7:4]};
				res.blue  = {hv[3:0], hv[3:0]};
			end
		end else if (path_q == cttr_pkg::PATH_DEC) begin
			res.ok    = 1'b1;
			res.red   = r_mul[13:6];
			res.green = g_mul[13:6];
			res.blue  = b_mul[13:6];
		end
	end

	// next state for one character
	always_comb begin
		path_d     = path_q;
		phase_d    = phase_q;
		len_d      = len_q;
		neg_d      = neg_q;
		hval_d     = hval_q;
		cons_d     = cons_q;
		dval_d     = dval_q;
		take_digit = 1'b0;
		if (q_data.term) begin
			path_d  = cttr_pkg::PATH_WAIT;
			phase_d = cttr_pkg::PH_WS;
			len_d   = '0;
			neg_d   = 1'b0;
			hval_d  = '0;
			cons_d  = '0;
			dval_d  = '0;
		end else begin
			if (len_q < cttr_pkg::MAX_LEN) begin
				len_d = len_q + 4'd1;
			end
			case (path_q)
				cttr_pkg::PATH_WAIT: begin
					if (q_data.hash) begin
						path_d = cttr_pkg::PATH_HEX;
					end else if (q_data.dec) begin
						path_d = cttr_pkg::PATH_DEC;
						dval_d = 16'(q_data.digit);
					end else begin
						path_d = cttr_pkg::PATH_BAD;
					end
				end
				cttr_pkg::PATH_DEC: begin
					if (q_data.dec) begin
						dval_d = (dval_q << 3) + (dval_q << 1) + 16'(q_data.digit);
					end else begin
						path_d = cttr_pkg::PATH_BAD;
					end
				end
				cttr_pkg::PATH_HEX: begin
					if (len_q < cttr_pkg::MAX_LEN) begin
						case (phase_q)
							cttr_pkg::PH_WS, cttr_pkg::PH_SIGNED: begin
								if (phase_q == cttr_pkg::PH_WS && q_data.ws) begin
									phase_d = phase_q;
								end else if (phase_q == cttr_pkg::PH_WS &&
								             (q_data.plus || q_data.minus)) begin
									neg_d   = q_data.minus;
									phase_d = cttr_pkg::PH_SIGNED;
								end else if (q_data.zero_ch) begin
									take_digit = 1'b1;
									phase_d    = cttr_pkg::PH_ZERO;
								end else if (q_data.hex) begin
									take_digit = 1'b1;
									phase_d    = cttr_pkg::PH_DIGITS;
								end else begin
									phase_d = cttr_pkg::PH_DONE;
								end
							end
							cttr_pkg::PH_ZERO: begin
								if (q_data.x_ch) begin
									phase_d = cttr_pkg::PH_ZEROX;
								end else if (q_data.hex) begin
									take_digit = 1'b1;
									phase_d    = cttr_pkg::PH_DIGITS;
								end else begin
									phase_d = cttr_pkg::PH_DONE;
								end
							end
							cttr_pkg::PH_ZEROX, cttr_pkg::PH_DIGITS: begin
								if (q_data.hex) begin
									take_digit = 1'b1;
									phase_d    = cttr_pkg::PH_DIGITS;
								end else begin
									phase_d = cttr_pkg::PH_DONE;
								end
							end
							default: begin
								phase_d = phase_q;
							end
						endcase
						if (take_digit) begin
							hval_d = {hval_q[19:0], q_data.digit};
							cons_d = len_q;
						end
					end
				end
				default: begin
					path_d = path_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_q      <= cttr_pkg::PATH_WAIT;
			phase_q     <= cttr_pkg::PH_WS;
			len_q       <= '0;
			neg_q       <= 1'b0;
			hval_q      <= '0;
			cons_q      <= '0;
			dval_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				path_q  <= path_d;
				phase_q <= phase_d;
				len_q   <= len_d;
				neg_q   <= neg_d;
				hval_q  <= hval_d;
				cons_q  <= cons_d;
				dval_q  <= dval_d;
			end
			if (take && q_data.term) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_data.term) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.blue, out_q.green, out_q.red, out_q.ok};

endmodule

### src/cttr_checker.sv
// Port-level checks for the color text parser, bound to the top level.
module cttr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an invalid color carries zero components
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[24:1] == 24'd0)
		else $error("invalid result with nonzero color");

	// pad bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:25] == 7'd0)
		else $error("nonzero pad bits");

	// an offered character and the ready answer are known
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown({s_tready, s_tdata}))
		else $error("unknown input handshake or character");

	// no result after an edge seen in reset
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind color_text_to_rgb_parser cttr_checker u_cttr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/sv/color_text_to_rgb_parser_tb.sv
// Self-checking testbench for the color text parser: streamed texts, predicted colors.
`timescale 1ns / 100ps

module color_text_to_rgb_parser_tb;

	localparam int          CLK_PERIOD   = 4;
	localparam int          RESET_CYCLES = 5;
	localparam logic [7:0]  TERMINATOR   = 8'h00;
	// Receiver hold-off long enough to fill the character queue and stall input
	localparam int          HOLD_CYCLES  = 300;
	// Quiet-cycle limit: the hold-off plus generous room for 57% random gaps
	// on both sides; a correct run stays far below this limit in its idle stretches
	// outside the hold-off.
	localparam int          QUIET_LIMIT  = 3000;
	// Spare edges at the end of the run, after the last result transfer
	localparam int          TAIL_CYCLES  = 8;
	localparam int          PHASE_CHARS  = 340;
	localparam int          HOLD_CHARS   = 60;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	color_text_to_rgb_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] ch
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // [0] ok, [8:1] red, [16:9] green, [24:17] blue
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stimulus and scoreboard storage
	logic [7:0]       pending_chars[$];
	cttr_pkg::color_t expected_colors[$];
	int               chars_queued  = 0;
	int               mismatches    = 0;
	int               quiet_cycles  = 0;

	// Idle controls; idle_pct, stall_pct and hold_requests change only between phases (at the falling edge)
	int         idle_pct      = 0;
	int         stall_pct     = 0;
	int         hold_requests = 0;
	int         holds_served  = 0;
	int         hold_left     = 0;

	// Parser state as predicted from accepted characters
	cttr_pkg::path_t  p_path  = cttr_pkg::PATH_WAIT;
	logic [3:0]       p_len   = '0;   // characters so far, '#' included, saturates at MAX_LEN
	cttr_pkg::phase_t p_phase = cttr_pkg::PH_WS;
	logic             p_neg   = 1'b0;
	logic [23:0]      p_hex   = '0;
	logic [3:0]       p_used  = '0;   // position of the last hex digit taken
	logic [15:0]      p_dec   = '0;

	function automatic logic [7:0] widen_565(input int unsigned c, input int unsigned mul,
			input int unsigned add);
		return 8'((c * mul + add) >> 6);
	endfunction

	// Advance the predicted parser by one accepted character; a terminator
	// yields the expected color and clears the state for the next text.
	task automatic parse_char(input logic [7:0] c);
		cttr_pkg::color_t res;
		logic [23:0]      v;
		logic [4:0]       nib;
		logic [3:0]       pos;
		logic             scan_first;
		logic             take;
		res        = '0;
		scan_first = 1'b0;
		take       = 1'b0;
		pos        = p_len;
		if (c == TERMINATOR) begin
			if (p_path == cttr_pkg::PATH_HEX && p_len < cttr_pkg::MAX_LEN) begin
				v = p_hex;
				if (p_neg)
					v = -v;
				if (p_used == cttr_pkg::HEX_LONG) begin
					res.ok    = 1'b1;
					res.red   = v[23:16];
					res.green = v[15:8];
					res.blue  = v[7:0];
				end else if (p_used == cttr_pkg::HEX_SHORT) begin
					// #rgb: each nibble doubled
					res.ok    = 1'b1;
					res.red   = {2{v[11:8]}};
					res.green = {2{v[7:4]}};
					res.blue  = {2{v[3:0]}};
				end
			end else if (p_path == cttr_pkg::PATH_DEC) begin
				res.ok    = 1'b1;
				res.red   = widen_565(p_dec[15:11], 527, 23);
				res.green = widen_565(p_dec[10:5], 259, 33);
				res.blue  = widen_565(p_dec[4:0], 527, 23);
			end
			expected_colors.push_back(res);
			p_path  = cttr_pkg::PATH_WAIT;
			p_len   = '0;
			p_phase = cttr_pkg::PH_WS;
			p_neg   = 1'b0;
			p_hex   = '0;
			p_used  = '0;
			p_dec   = '0;
			return;
		end

		if (p_len < cttr_pkg::MAX_LEN)
			p_len = p_len + 4'd1;

		if (c >= "0" && c <= "9")
			nib = {1'b0, c[3:0]};
		else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			nib = 5'(c[3:0] + 4'd9);
		else
			nib = 5'd16;

		case (p_path)
			cttr_pkg::PATH_WAIT: begin
				if (c == "#") begin
					p_path = cttr_pkg::PATH_HEX;
				end else if (c >= "0" && c <= "9") begin
					p_path = cttr_pkg::PATH_DEC;
					p_dec  = {12'd0, c[3:0]};
				end else begin
					p_path = cttr_pkg::PATH_BAD;
				end
			end
			cttr_pkg::PATH_DEC: begin
				if (c >= "0" && c <= "9")
					p_dec = p_dec * 16'd10 + {12'd0, c[3:0]};
				else
					p_path = cttr_pkg::PATH_BAD;
			end
			cttr_pkg::PATH_HEX: begin
				// only the seven characters after the '#' feed the number scanner
				if (pos < cttr_pkg::MAX_LEN) begin
					case (p_phase)
						cttr_pkg::PH_WS: begin
							if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
								// leading whitespace skipped
							end else if (c == "+" || c == "-") begin
								p_neg   = (c == "-");
								p_phase = cttr_pkg::PH_SIGNED;
							end else begin
								scan_first = 1'b1;
							end
						end
						cttr_pkg::PH_SIGNED: scan_first = 1'b1;
						cttr_pkg::PH_ZERO: begin
							if (c == "x" || c == "X") begin
								p_phase = cttr_pkg::PH_ZEROX;
							end else if (nib < 5'd16) begin
								take    = 1'b1;
								p_phase = cttr_pkg::PH_DIGITS;
							end else begin
								p_phase = cttr_pkg::PH_DONE;
							end
						end
						cttr_pkg::PH_ZEROX, cttr_pkg::PH_DIGITS: begin
							if (nib < 5'd16) begin
								take    = 1'b1;
								p_phase = cttr_pkg::PH_DIGITS;
							end else begin
								p_phase = cttr_pkg::PH_DONE;
							end
						end
						default: ;
					endcase
					if (scan_first) begin
						// a leading '0' may open a 0x prefix
						if (nib < 5'd16) begin
							take    = 1'b1;
							p_phase = (c == "0") ? cttr_pkg::PH_ZERO : cttr_pkg::PH_DIGITS;
						end else begin
							p_phase = cttr_pkg::PH_DONE;
						end
					end
					if (take) begin
						p_hex  = {p_hex[19:0], nib[3:0]};
						p_used = pos;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Sender: one transfer per character, random gaps at idle_pct percent
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parse_char(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_chars.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transfer against the oldest prediction
	always @(posedge clk) begin
		cttr_pkg::color_t got;
		cttr_pkg::color_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.ok    = m_tdata[0];
				got.red   = m_tdata[8:1];
				got.green = m_tdata[16:9];
				got.blue  = m_tdata[24:17];
				if (expected_colors.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with none expected: ok=%0b r=%02h g=%02h b=%02h",
							$realtime, got.ok, got.red, got.green, got.blue);
					mismatches++;
				end else begin
					want = expected_colors.pop_front();
					if (got.ok !== want.ok || got.red !== want.red ||
							got.green !== want.green || got.blue !== want.blue) begin
						if (mismatches < 10)
							$display({"%0t: color mismatch: expected ok=%0b r=%02h g=%02h b=%02h,",
								" got ok=%0b r=%02h g=%02h b=%02h"}, $realtime,
								want.ok, want.red, want.green, want.blue,
								got.ok, got.red, got.green, got.blue);
						mismatches++;
					end
				end
			end
			// a new hold request starts a long stretch of back-pressure
			if (hold_requests != holds_served) begin
				holds_served <= hold_requests;
				hold_left    <= HOLD_CYCLES;
				m_tready     <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("color_text_to_rgb_parser_tb: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back(c);
		chars_queued++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
		push_char(TERMINATOR);
	endtask

	function automatic logic [7:0] random_hex_char();
		logic [7:0] n;
		n = 8'($urandom_range(15));
		if (n < 8'd10)
			return "0" + n;
		return n + ($urandom_range(1) ? ("a" - 8'd10) : ("A" - 8'd10));
	endfunction

	// One random text plus terminator. Half are mostly well-formed hex texts with
	// random prefixes aimed at 3 or 6 consumed characters, the rest decimal
	// (sometimes long or broken) and raw byte noise.
	task automatic queue_random_text();
		int roll;
		int lead;
		int digits;
		int target;
		roll = $urandom_range(9);
		if (roll < 5) begin
			push_char("#");
			lead = 0;
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 2)) begin
					push_char($urandom_range(1) ? 8'h20 : 8'($urandom_range(9, 13)));
					lead++;
				end
			end
			if ($urandom_range(3) == 0) begin
				push_char($urandom_range(1) ? "-" : "+");
				lead++;
			end
			if ($urandom_range(3) == 0) begin
				push_char("0");
				push_char($urandom_range(1) ? "x" : "X");
				lead += 2;
			end
			target = $urandom_range(1) ? 6 : 3;
			if ($urandom_range(4) == 0)
				digits = $urandom_range(0, 7);
			else
				digits = (target > lead) ? target - lead : 1;
			repeat (digits)
				push_char(random_hex_char());
			// trailing text after the number
			if ($urandom_range(2) == 0)
				repeat ($urandom_range(1, 2))
					push_char(8'($urandom_range(1, 255)));
		end else if (roll < 8) begin
			digits = ($urandom_range(4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
			repeat (digits)
				push_char(8'("0" + $urandom_range(9)));
			if ($urandom_range(5) == 0) begin
				push_char(8'($urandom_range(1, 255)));
				repeat ($urandom_range(0, 2))
					push_char(8'("0" + $urandom_range(9)));
			end
		end else begin
			if ($urandom_range(2) == 0)
				push_char("#");
			repeat ($urandom_range(0, 9))
				push_char(8'($urandom_range(1, 255)));
		end
		push_char(TERMINATOR);
	endtask

	// Sender pause: everything accepted and every predicted color received
	task automatic wait_drained();
		@(negedge clk);
		while (pending_chars.size() != 0 || s_tvalid || expected_colors.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int start;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed texts: empty, #rgb with digit extremes, negative #rgb,
		// bare 0x, no hex digits, largest RGB565 value, #rrggbb
		queue_text("");
		queue_text("#0aF");
		queue_text("#-ab");
		queue_text("#0x");
		queue_text("#q");
		queue_text("65535");
		queue_text("#1a2B3c");
		wait_drained();

		// Random phases: no idling, sender gaps, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 57 : (ph == 3) ? 34 : 0;
			stall_pct = (ph == 2) ? 57 : (ph == 3) ? 34 : 0;
			start = chars_queued;
			while (chars_queued - start < PHASE_CHARS)
				queue_random_text();
			wait_drained();
		end

		// Long receiver hold-off while short texts keep arriving, so the
		// held terminators fill the block and input backs up
		idle_pct  = 0;
		stall_pct = 0;
		hold_requests++;
		start = chars_queued;
		while (chars_queued - start < HOLD_CHARS) begin
			if ($urandom_range(9) < 3)
				push_char(8'("0" + $urandom_range(9)));
			push_char(TERMINATOR);
		end
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_colors.size() == 0)
			$display("color_text_to_rgb_parser_tb: clean");
		else
			$display("color_text_to_rgb_parser_tb: errors");
		$finish;
	end

endmodule

### color_text_to_rgb_parser.f
src/cttr_pkg.sv
src/cttr_front.sv
src/cttr_queue.sv
src/cttr_back.sv
src/color_text_to_rgb_parser.sv
src/cttr_checker.sv
tb/sv/color_text_to_rgb_parser_tb.sv
